>>> rtl/core/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants of the lfu cache table: controller states,
// pass kinds, command and status bundles, field widths.
// ----------------------------------------------------------------------------
package lct_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 32;
    localparam int CAP_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET  = 7'd64;
    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};
    localparam logic             FUNC_GET   = 1'b0;
    localparam logic             FUNC_PUT   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PASS_CLEAR,
        PASS_SCAN,
        PASS_UPDATE
    } pass_t;

    typedef struct packed {
        logic load_in;
        logic start_scan;
        logic start_update;
        logic decide;
        logic emit;
    } lct_cmd_t;

    typedef struct packed {
        logic pass_done;
        logic need_update;
        logic out_free;
    } lct_status_t;

endpackage

>>> rtl/core/lct_ctrl.sv
// ----------------------------------------------------------------------------
// lct_ctrl
// Controller: sequences the clearing pass, the scan pass, the decision step,
// the update pass and the result handoff.
// ----------------------------------------------------------------------------
module lct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lct_pkg::lct_status_t status,
    output lct_pkg::lct_cmd_t    cmd
);
    import lct_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.pass_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in    = 1'b1;
                    cmd.start_scan = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.pass_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (status.need_update)
                begin
                    cmd.start_update = 1'b1;
                    state_next       = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_UPDATE:
            begin
                if (status.pass_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/lct_datapath.sv
// ----------------------------------------------------------------------------
// lct_datapath
// Entry memory with a sweeping address counter, scan trackers for the key
// match, the eviction victim and the first free slot, the per-entry rewrite
// of the update pass, the capacity register and the result register.
// ----------------------------------------------------------------------------
module lct_datapath #(
    parameter int ENTRIES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lct_pkg::CAP_W-1:0]     cfg_wdata,
    input  logic                          in_func,
    input  logic [lct_pkg::KEY_W-1:0]     in_key,
    input  logic [lct_pkg::VAL_W-1:0]     in_value,
    input  lct_pkg::lct_cmd_t             cmd,
    output lct_pkg::lct_status_t          status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_hit,
    output logic [lct_pkg::VAL_W-1:0]     out_read_value,
    output logic                          out_evicted
);
    import lct_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic [IW-1:0]    rank;
    } entry_t;

    entry_t mem [ENTRIES];
    entry_t rdata_reg;
    entry_t wdata;
    logic   mem_we;
    logic [IW-1:0] mem_waddr;

    // pass engine
    pass_t         mode_reg;
    logic          run_reg;
    logic [CW-1:0] cnt_reg;
    logic          rd_vld_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          last_issue;

    // current item
    logic             func_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;

    // scan trackers
    logic             found_reg;
    logic [IW-1:0]    fidx_reg;
    logic [IW-1:0]    frank_reg;
    logic [VAL_W-1:0] fvalue_reg;
    logic             vfound_reg;
    logic [IW-1:0]    vidx_reg;
    logic [IW-1:0]    vrank_reg;
    logic [CNT_W-1:0] vcount_reg;
    logic             free_found_reg;
    logic [IW-1:0]    free_idx_reg;

    // decision
    logic          ins_reg;
    logic          hitupd_reg;
    logic          evict_reg;
    logic [IW-1:0] slot_reg;
    logic [CW-1:0] live_reg;

    logic [CAP_W-1:0] capacity_reg;
    logic [LW-1:0]    cap_eff;
    logic             cap_zero;
    logic             need_evict;
    logic             ins_now;

    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_ev_reg;

    assign last_issue = (cnt_reg == CW'(ENTRIES - 1));
    assign cap_zero   = (capacity_reg == '0);
    assign cap_eff    = (LW'(capacity_reg) > LW'(ENTRIES)) ? LW'(ENTRIES) : LW'(capacity_reg);
    assign need_evict = (LW'(live_reg) >= cap_eff);
    assign ins_now    = (func_reg == FUNC_PUT) && !cap_zero && !found_reg;

    always_comb
    begin
        status.pass_done = (mode_reg == PASS_CLEAR) ? (run_reg && last_issue)
                         : (rd_vld_reg && (rd_idx_reg == IW'(ENTRIES - 1)));
        status.need_update = (func_reg == FUNC_GET) ? found_reg : !cap_zero;
        status.out_free    = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    // the pass engine starts out of reset with the clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= PASS_CLEAR;
            run_reg    <= 1'b1;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= run_reg && (mode_reg != PASS_CLEAR);
            rd_idx_reg <= cnt_reg[IW-1:0];
            if (cmd.start_scan || cmd.start_update)
            begin
                mode_reg <= cmd.start_scan ? PASS_SCAN : PASS_UPDATE;
                run_reg  <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last_issue)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            rdata_reg <= mem[cnt_reg[IW-1:0]];
        end
        if (mem_we)
        begin
            mem[mem_waddr] <= wdata;
        end
    end

    // rewrite of one entry during the update pass, or zeroing of one during the clearing pass
    always_comb
    begin
        wdata     = rdata_reg;
        mem_we    = 1'b0;
        mem_waddr = rd_idx_reg;
        case (mode_reg)
            PASS_CLEAR:
            begin
                wdata     = '0;
                mem_we    = run_reg;
                mem_waddr = cnt_reg[IW-1:0];
            end
            PASS_UPDATE:
            begin
                mem_we = rd_vld_reg;
                if (hitupd_reg)
                begin
                    if (rd_idx_reg == fidx_reg)
                    begin
                        wdata.rank = '0;
                        if (rdata_reg.count != {CNT_W{1'b1}})
                        begin
                            wdata.count = rdata_reg.count + CNT_W'(1);
                        end
                        if (func_reg == FUNC_PUT)
                        begin
                            wdata.value = val_reg;
                        end
                    end
                    else if (rdata_reg.valid && (rdata_reg.rank < frank_reg))
                    begin
                        wdata.rank = rdata_reg.rank + IW'(1);
                    end
                end
                else if (ins_reg)
                begin
                    if (rdata_reg.valid)
                    begin
                        if (evict_reg && (rd_idx_reg == vidx_reg))
                        begin
                            wdata.valid = 1'b0;
                        end
                        else if (!(evict_reg && (rdata_reg.rank > vrank_reg)))
                        begin
                            // ranks above the victim close the gap, the new item pushes all
                            wdata.rank = rdata_reg.rank + IW'(1);
                        end
                    end
                    if (rd_idx_reg == slot_reg)
                    begin
                        wdata.valid = 1'b1;
                        wdata.key   = key_reg;
                        wdata.value = val_reg;
                        wdata.count = CNT_W'(1);
                        wdata.rank  = '0;
                    end
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= in_func;
            key_reg  <= in_key;
            val_reg  <= in_value;
        end
        if (rd_vld_reg && (mode_reg == PASS_SCAN))
        begin
            if (rdata_reg.valid && (rdata_reg.key == key_reg))
            begin
                fidx_reg   <= rd_idx_reg;
                frank_reg  <= rdata_reg.rank;
                fvalue_reg <= rdata_reg.value;
            end
            if (rdata_reg.valid && (!vfound_reg || (rdata_reg.count < vcount_reg) ||
                ((rdata_reg.count == vcount_reg) && (rdata_reg.rank > vrank_reg))))
            begin
                vidx_reg   <= rd_idx_reg;
                vrank_reg  <= rdata_reg.rank;
                vcount_reg <= rdata_reg.count;
            end
            if (!rdata_reg.valid && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
        end
        if (cmd.decide)
        begin
            if (need_evict && (!free_found_reg || (vidx_reg < free_idx_reg)))
            begin
                slot_reg <= vidx_reg;
            end
            else
            begin
                slot_reg <= free_idx_reg;
            end
        end
        if (cmd.emit)
        begin
            out_hit_reg   <= found_reg;
            out_ev_reg    <= evict_reg;
            out_value_reg <= (func_reg == FUNC_PUT) ? '0
                           : (found_reg ? fvalue_reg : MISS_VALUE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            vfound_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            ins_reg        <= 1'b0;
            hitupd_reg     <= 1'b0;
            evict_reg      <= 1'b0;
            live_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start_scan)
            begin
                found_reg      <= 1'b0;
                vfound_reg     <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (rd_vld_reg && (mode_reg == PASS_SCAN))
            begin
                if (rdata_reg.valid && (rdata_reg.key == key_reg))
                begin
                    found_reg <= 1'b1;
                end
                if (rdata_reg.valid)
                begin
                    vfound_reg <= 1'b1;
                end
                else
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.decide)
            begin
                ins_reg    <= ins_now;
                hitupd_reg <= found_reg && ((func_reg == FUNC_GET) || !cap_zero);
                evict_reg  <= ins_now && need_evict;
                if (ins_now && !need_evict)
                begin
                    live_reg <= live_reg + CW'(1);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_hit        = out_hit_reg;
    assign out_read_value = out_value_reg;
    assign out_evicted    = out_ev_reg;

`ifndef NO_ASSERTIONS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(ENTRIES))
        else $error("live count above table size");

    a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide && ins_now && !need_evict) |-> free_found_reg)
        else $error("insert without eviction found no free slot");

    a_evict_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide && ins_now && need_evict) |-> vfound_reg)
        else $error("eviction without a valid victim");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

>>> rtl/core/lfu_cache_table_top.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_top
// LFU key-value cache with least-recently-used tie break on eviction.
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one item: s_tuser is the operation (0 get, 1 put),
//   s_tdata holds key then value. m_* channel returns one result per item:
//   m_tdata is the read value, m_tuser holds hit then evicted.
//   cfg_we / cfg_wdata write the capacity register (reset 64, 0 stops puts);
//   write it only while no item is in flight.
// timing:
//   every item runs a scan pass over all ENTRIES memory words, one per cycle,
//   then a decision step; hits and inserts add a rewrite pass over all
//   words. one item is in work at a time, and the entry memory has a single
//   port pair.
// reset:
//   a clearing sweep zeroes the entry memory; s_tready stays low until
//   it ends.
// stalls:
//   a result waits in the output register; the next item is taken meanwhile
//   and holds in its last step until the register is free.
// ----------------------------------------------------------------------------
module lfu_cache_table_top #(
    parameter int ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key, value
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value
    output logic [1:0]  m_tuser    // hit, evicted
);
    import lct_pkg::*;

    lct_cmd_t    cmd;
    lct_status_t status;
    logic        hit;
    logic        evicted;

    lct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lct_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_func        (s_tuser),
        .in_key         (s_tdata[31:0]),
        .in_value       (s_tdata[63:32]),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_hit        (hit),
        .out_read_value (m_tdata),
        .out_evicted    (evicted)
    );

    assign m_tuser = {evicted, hit};

endmodule
